// ===== rtl/bsog_pkg.sv =====
// Shared widths, codes and table entry type for the broadcast stride offset generator.
// No dependencies.
`default_nettype none
package bsog_pkg;

  localparam int MAX_RANK = 8;
  localparam int DIM_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int ACT_W    = $clog2(MAX_RANK + 1);
  localparam int RANK_W   = 4;
  localparam int SEL_W    = 3;
  localparam int SIZE_W   = 32;
  localparam int IDX_W    = 40;
  localparam int PROD_W   = 2 * SIZE_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOBCAST  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BADDIM   = 2'd3;

  // one dimension: output size and the two operand strides
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] lst;
    logic [SIZE_W-1:0] rst;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/bsog_table.sv =====
// Dimension table: MAX_RANK entries of size and strides, one write and one
// registered read port. Depends on bsog_pkg.
`default_nettype none
module bsog_table (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [bsog_pkg::DIM_W-1:0] wr_addr,
  input  wire bsog_pkg::entry_t           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [bsog_pkg::DIM_W-1:0] rd_addr,
  output bsog_pkg::entry_t                rd_data
);

  bsog_pkg::entry_t mem [bsog_pkg::MAX_RANK];
  bsog_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/bsog_div.sv =====
// Restoring divider, one quotient bit per cycle: 40-bit dividend by 32-bit divisor.
// Depends on bsog_pkg.
`default_nettype none
module bsog_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bsog_pkg::IDX_W-1:0]  dividend,
  input  wire logic [bsog_pkg::SIZE_W-1:0] divisor,
  output logic                             done,
  output logic [bsog_pkg::IDX_W-1:0]       quotient,
  output logic [bsog_pkg::SIZE_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(bsog_pkg::IDX_W + 1);

  logic [bsog_pkg::IDX_W-1:0]  q_r, q_nxt;
  logic [bsog_pkg::SIZE_W-1:0] r_r, r_nxt;
  logic [bsog_pkg::SIZE_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [bsog_pkg::SIZE_W:0]   trial;
  logic [bsog_pkg::SIZE_W:0]   diff;

  always_comb begin
    trial    = {r_r, q_r[bsog_pkg::IDX_W-1]};
    diff     = trial - {1'b0, den_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      r_nxt   = '0;
      den_nxt = divisor;
      cnt_nxt = CNT_W'(bsog_pkg::IDX_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        r_nxt = diff[bsog_pkg::SIZE_W-1:0];
        q_nxt = {q_r[bsog_pkg::IDX_W-2:0], 1'b1};
      end else begin
        r_nxt = trial[bsog_pkg::SIZE_W-1:0];
        q_nxt = {q_r[bsog_pkg::IDX_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule
`default_nettype wire

// ===== rtl/broadcast_stride_offset_generator.sv =====
// Broadcast stride offset generator. Load word: result strobed in the cycle after start.
// Query word: per active dimension a table read, setup, bit-serial divide, multiply and
// accumulate (no divide where the stored size is zero), then the result; busy stays
// high meanwhile, one word at a time. A query at rank zero answers like a load.
// The divider sets the rate. Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears rank, control state and the strobe; table contents
// are undefined until loaded. Depends on bsog_pkg, bsog_table, bsog_div.
`default_nettype none
module broadcast_stride_offset_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_command,
  input  wire logic [bsog_pkg::SEL_W-1:0]  in_dim_index,
  input  wire logic [bsog_pkg::SIZE_W-1:0] in_lhs_size,
  input  wire logic [bsog_pkg::SIZE_W-1:0] in_rhs_size,
  input  wire logic [bsog_pkg::SIZE_W-1:0] in_lhs_stride,
  input  wire logic [bsog_pkg::SIZE_W-1:0] in_rhs_stride,
  input  wire logic [bsog_pkg::IDX_W-1:0]  in_linear_index,
  output logic                             out_valid,
  output logic [bsog_pkg::IDX_W-1:0]       out_lhs_offset,
  output logic [bsog_pkg::IDX_W-1:0]       out_rhs_offset,
  output logic [bsog_pkg::SIZE_W-1:0]      out_dim_size,
  output logic [1:0]                       out_status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bsog_pkg::RANK_W-1:0] cfg_rank
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_SETUP = 6'b000100,
    S_DIV   = 6'b001000,
    S_MUL   = 6'b010000,
    S_ACC   = 6'b100000
  } state_t;

  localparam int CMP_W = bsog_pkg::RANK_W + 1;

  state_t                        state_r, state_nxt;
  logic [bsog_pkg::RANK_W-1:0]   rank_r, rank_nxt;
  logic [bsog_pkg::DIM_W-1:0]    k_r, k_nxt;
  logic [bsog_pkg::IDX_W-1:0]    rem_r, rem_nxt;
  logic [bsog_pkg::SIZE_W-1:0]   coord_r, coord_nxt;
  logic [bsog_pkg::PROD_W-1:0]   prod_l_r, prod_l_nxt;
  logic [bsog_pkg::PROD_W-1:0]   prod_r_r, prod_r_nxt;
  logic [bsog_pkg::IDX_W-1:0]    acc_l_r, acc_l_nxt;
  logic [bsog_pkg::IDX_W-1:0]    acc_r_r, acc_r_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bsog_pkg::IDX_W-1:0]    out_lhs_r, out_lhs_nxt;
  logic [bsog_pkg::IDX_W-1:0]    out_rhs_r, out_rhs_nxt;
  logic [bsog_pkg::SIZE_W-1:0]   out_size_r, out_size_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;

  localparam int ACT_W_L = bsog_pkg::ACT_W;
  logic [ACT_W_L-1:0]            act_rank;
  logic                          accept;
  logic                          dim_ok;
  logic                          bcast_ok;
  logic [bsog_pkg::SIZE_W-1:0]   osz;
  logic                          tbl_wr;
  bsog_pkg::entry_t              tbl_wdata;
  logic                          tbl_rd;
  bsog_pkg::entry_t              tbl_rdata;
  logic                          div_start;
  logic                          div_done;
  logic [bsog_pkg::IDX_W-1:0]    div_quot;
  logic [bsog_pkg::SIZE_W-1:0]   div_rem;
  logic [bsog_pkg::IDX_W:0]      sum_l;
  logic [bsog_pkg::IDX_W:0]      sum_r;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // ranks above the table depth act as the full depth
  assign act_rank = ({1'b0, rank_r} > CMP_W'(bsog_pkg::MAX_RANK))
                  ? ACT_W_L'(bsog_pkg::MAX_RANK) : ACT_W_L'(rank_r);

  assign dim_ok   = CMP_W'(in_dim_index) < CMP_W'(act_rank);
  assign bcast_ok = (in_lhs_size == in_rhs_size) || (in_lhs_size == 32'd1)
                 || (in_rhs_size == 32'd1);
  assign osz      = (in_lhs_size > in_rhs_size) ? in_lhs_size : in_rhs_size;

  assign tbl_wr         = accept && (in_command == bsog_pkg::CMD_LOAD) && dim_ok && bcast_ok;
  assign tbl_wdata.size = osz;
  assign tbl_wdata.lst  = (in_lhs_size == osz) ? in_lhs_stride : '0;
  assign tbl_wdata.rst  = (in_rhs_size == osz) ? in_rhs_stride : '0;
  assign tbl_rd         = (state_r == S_RD);
  assign div_start      = (state_r == S_SETUP) && (tbl_rdata.size != '0);

  assign sum_l = {1'b0, acc_l_r} + {1'b0, prod_l_r[bsog_pkg::IDX_W-1:0]};
  assign sum_r = {1'b0, acc_r_r} + {1'b0, prod_r_r[bsog_pkg::IDX_W-1:0]};

  bsog_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (bsog_pkg::DIM_W'(in_dim_index)),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_rd),
    .rd_addr (k_r),
    .rd_data (tbl_rdata)
  );

  bsog_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_r),
    .divisor   (tbl_rdata.size),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    rank_nxt       = rank_r;
    k_nxt          = k_r;
    rem_nxt        = rem_r;
    coord_nxt      = coord_r;
    prod_l_nxt     = prod_l_r;
    prod_r_nxt     = prod_r_r;
    acc_l_nxt      = acc_l_r;
    acc_r_nxt      = acc_r_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = 1'b0;
    out_lhs_nxt    = out_lhs_r;
    out_rhs_nxt    = out_rhs_r;
    out_size_nxt   = out_size_r;
    out_status_nxt = out_status_r;

    if (cfg_valid && cfg_ready) begin
      rank_nxt = cfg_rank;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == bsog_pkg::CMD_LOAD) begin
            out_valid_nxt  = 1'b1;
            out_lhs_nxt    = '0;
            out_rhs_nxt    = '0;
            out_size_nxt   = '0;
            if (!dim_ok) begin
              out_status_nxt = bsog_pkg::ST_BADDIM;
            end else if (!bcast_ok) begin
              out_status_nxt = bsog_pkg::ST_NOBCAST;
            end else begin
              out_status_nxt = bsog_pkg::ST_OK;
              out_size_nxt   = osz;
            end
          end else if (act_rank == '0) begin
            out_valid_nxt  = 1'b1;
            out_lhs_nxt    = '0;
            out_rhs_nxt    = '0;
            out_size_nxt   = '0;
            out_status_nxt = bsog_pkg::ST_OK;
          end else begin
            rem_nxt   = in_linear_index;
            k_nxt     = bsog_pkg::DIM_W'(act_rank - 1'b1);
            acc_l_nxt = '0;
            acc_r_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        // a zero size swallows the rest of the index
        if (tbl_rdata.size == '0) begin
          coord_nxt = '0;
          rem_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          coord_nxt = div_rem;
          rem_nxt   = div_quot;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_l_nxt = bsog_pkg::PROD_W'(coord_r) * bsog_pkg::PROD_W'(tbl_rdata.lst);
        prod_r_nxt = bsog_pkg::PROD_W'(coord_r) * bsog_pkg::PROD_W'(tbl_rdata.rst);
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        acc_l_nxt = sum_l[bsog_pkg::IDX_W-1:0];
        acc_r_nxt = sum_r[bsog_pkg::IDX_W-1:0];
        ovf_nxt   = ovf_r || sum_l[bsog_pkg::IDX_W] || sum_r[bsog_pkg::IDX_W]
                 || (prod_l_r[bsog_pkg::PROD_W-1:bsog_pkg::IDX_W] != '0)
                 || (prod_r_r[bsog_pkg::PROD_W-1:bsog_pkg::IDX_W] != '0);
        if (k_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_lhs_nxt    = acc_l_nxt;
          out_rhs_nxt    = acc_r_nxt;
          out_size_nxt   = '0;
          out_status_nxt = ovf_nxt ? bsog_pkg::ST_OVERFLOW : bsog_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    rem_r        <= rem_nxt;
    coord_r      <= coord_nxt;
    prod_l_r     <= prod_l_nxt;
    prod_r_r     <= prod_r_nxt;
    acc_l_r      <= acc_l_nxt;
    acc_r_r      <= acc_r_nxt;
    ovf_r        <= ovf_nxt;
    out_lhs_r    <= out_lhs_nxt;
    out_rhs_r    <= out_rhs_nxt;
    out_size_r   <= out_size_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_lhs_offset = out_lhs_r;
  assign out_rhs_offset = out_rhs_r;
  assign out_dim_size   = out_size_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire
